// ===== rtl/core/crc8fb_pkg.sv =====
// crc8fb_pkg: shared types, frame constants and the crc-8 byte update
// used by the front, queue, back and top of the crc-8 frame builder
// no dependencies
`timescale 1ns / 1ps

package crc8fb_pkg;

    localparam logic [7:0] CRC_POLY           = 8'h8C;
    localparam logic [7:0] HDR0_BYTE          = 8'hAF;
    localparam logic [7:0] HDR1_BYTE          = 8'hAA;
    localparam logic [7:0] TRL0_BYTE          = 8'hBF;
    localparam logic [7:0] TRL1_BYTE          = 8'hBB;
    localparam logic [7:0] LEN_MIN            = 8'd2;
    localparam logic [7:0] PAYLOAD_LENGTH_RST = 8'd10;
    localparam int         QUEUE_DEPTH        = 4;

    // one classified payload byte on its way to the back end
    typedef struct packed {
        logic       first;
        logic       last;
        logic [7:0] len;
        logic [7:0] data;
    } item_t;

    typedef enum logic [2:0] {
        PH_NEXT,
        PH_HDR1,
        PH_LEN,
        PH_DATA,
        PH_CRC,
        PH_TRL0,
        PH_TRL1
    } phase_t;

    // reflected crc-8, one byte, lsb first
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc8fb_front.sv =====
// crc8fb_front: holds the payload length register, counts payload bytes
// and tags each accepted byte as first or last of its frame
// depends on crc8fb_pkg
`timescale 1ns / 1ps

module crc8fb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_data,
    input  logic                q_full,
    output logic                q_push,
    output crc8fb_pkg::item_t   q_item
);
    import crc8fb_pkg::*;

    logic [7:0] payload_length_reg;
    logic [7:0] byte_index_reg;
    logic [7:0] byte_index_next;
    logic [7:0] len_eff;
    logic       is_last;

    // lengths below two act as two
    assign len_eff  = (payload_length_reg < LEN_MIN) ? LEN_MIN : payload_length_reg;
    assign is_last  = ({1'b0, byte_index_reg} + 9'd1) >= {1'b0, len_eff};
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.first = (byte_index_reg == 8'd0);
        q_item.last  = is_last;
        q_item.len   = len_eff;
        q_item.data  = in_data;
    end

    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (q_push)
        begin
            byte_index_next = is_last ? 8'd0 : byte_index_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_length_reg <= PAYLOAD_LENGTH_RST;
            byte_index_reg     <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                payload_length_reg <= cfg_wdata;
            end
            byte_index_reg <= byte_index_next;
        end
    end

endmodule

// ===== rtl/core/crc8fb_queue.sv =====
// crc8fb_queue: short show-ahead queue of classified items between
// the front and the back end
// depends on crc8fb_pkg
`timescale 1ns / 1ps

module crc8fb_queue #(
    parameter int DEPTH = crc8fb_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  crc8fb_pkg::item_t   push_item,
    output logic                full,
    input  logic                pop,
    output crc8fb_pkg::item_t   head_item,
    output logic                head_valid
);
    import crc8fb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/crc8fb_back.sv =====
// crc8fb_back: expands queued items into frame beats, runs the crc
// and holds the output register
// depends on crc8fb_pkg
`timescale 1ns / 1ps

module crc8fb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  crc8fb_pkg::item_t   q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_end
);
    import crc8fb_pkg::*;

    phase_t     state_reg;
    phase_t     state_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       out_end_reg;
    logic       out_end_next;
    logic       adv;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_end;
    logic       crc_en;
    logic       crc_clr;
    logic       pop_req;
    logic [7:0] crc_base;

    assign adv       = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_end   = out_end_reg;
    assign q_pop     = pop_req && adv;

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (adv)
        begin
            unique case (state_reg)
                PH_NEXT:
                begin
                    if (q_valid)
                    begin
                        if (q_item.first)
                        begin
                            state_next = PH_HDR1;
                        end
                        else if (q_item.last)
                        begin
                            state_next = PH_CRC;
                        end
                    end
                end
                PH_HDR1: state_next = PH_LEN;
                PH_LEN:  state_next = PH_DATA;
                PH_DATA: state_next = q_item.last ? PH_CRC : PH_NEXT;
                PH_CRC:  state_next = PH_TRL0;
                PH_TRL0: state_next = PH_TRL1;
                PH_TRL1: state_next = PH_NEXT;
                default: state_next = PH_NEXT;
            endcase
        end
    end

    // beat and crc control
    always_comb
    begin
        emit      = 1'b0;
        emit_byte = q_item.data;
        emit_end  = 1'b0;
        crc_en    = 1'b0;
        crc_clr   = 1'b0;
        pop_req   = 1'b0;
        unique case (state_reg)
            PH_NEXT:
            begin
                if (q_valid)
                begin
                    emit   = 1'b1;
                    crc_en = 1'b1;
                    if (q_item.first)
                    begin
                        emit_byte = HDR0_BYTE;
                        crc_clr   = 1'b1;
                    end
                    else
                    begin
                        pop_req = 1'b1;
                    end
                end
            end
            PH_HDR1:
            begin
                emit      = 1'b1;
                emit_byte = HDR1_BYTE;
                crc_en    = 1'b1;
            end
            PH_LEN:
            begin
                emit      = 1'b1;
                emit_byte = q_item.len;
                crc_en    = 1'b1;
            end
            PH_DATA:
            begin
                emit    = 1'b1;
                crc_en  = 1'b1;
                pop_req = 1'b1;
            end
            PH_CRC:
            begin
                emit      = 1'b1;
                emit_byte = crc_reg;
            end
            PH_TRL0:
            begin
                emit      = 1'b1;
                emit_byte = TRL0_BYTE;
            end
            PH_TRL1:
            begin
                emit      = 1'b1;
                emit_byte = TRL1_BYTE;
                emit_end  = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign crc_base = crc_clr ? 8'd0 : crc_reg;

    always_comb
    begin
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        if (adv)
        begin
            out_valid_next = emit;
            out_byte_next  = emit_byte;
            out_end_next   = emit_end;
            if (crc_en)
            begin
                crc_next = crc_byte(crc_base, emit_byte);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_NEXT;
            crc_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
            out_end_reg   <= out_end_next;
        end
    end

endmodule

// ===== rtl/core/crc8_frame_builder_top.sv =====
// a payload byte passes the queue and then the output register to its first beat
// throughput: one beat per cycle from the back end while not stalled; the first
// and last payload bytes of a frame give four beats each, the others one beat
// input bytes are taken every cycle while the queue (QUEUE_DEPTH items) has room
// reset: asynchronous, active low; empties the queue, clears the byte count
// and crc, and sets the payload length to 10
`timescale 1ns / 1ps

module crc8_frame_builder_top #(
    parameter int QUEUE_DEPTH = crc8fb_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,     // payload_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // payload_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // frame_byte
    output logic        m_tlast
);
    import crc8fb_pkg::*;

    item_t  push_item;
    item_t  head_item;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;

    crc8fb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    crc8fb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_item  (head_item),
        .head_valid (q_valid)
    );

    crc8fb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_end   (m_tlast)
    );

    a_last_is_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == TRL1_BYTE)
        else $error("frame end beat is not the closing trailer byte");

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && push_item.first |-> !push_item.last)
        else $error("byte tagged both first and last of a frame");

endmodule

// ===== test/tb_crc8_frame_builder_top.sv =====
// tb_crc8_frame_builder_top: self-checking testbench for the crc-8 frame builder,
// predicting header, length, payload, crc and trailer beats and comparing each output beat
// depends on crc8fb_pkg and crc8_frame_builder_top only
`timescale 1ns / 1ps

module tb_crc8_frame_builder_top;

    import crc8fb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'd0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // frame builder state as seen from outside
    logic [7:0]  cur_length = PAYLOAD_LENGTH_RST;
    logic [7:0]  frame_pos  = 8'd0;
    logic [7:0]  frame_crc  = 8'd0;
    frame_beat_t pending_beats[$];

    bit gaps_on     = 1'b0;
    int rx_hold_req = 0;
    int rx_stall    = 0;
    int quiet_cycles = 0;

    int mismatches       = 0;
    int payload_sent     = 0;
    int frames_done      = 0;
    int beats_checked    = 0;
    int settings_written = 0;

    crc8_frame_builder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // bit-serial reflected crc-8
    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ data[i])
            begin
                r = {1'b0, r[7:1]} ^ CRC_POLY;
            end
            else
            begin
                r = {1'b0, r[7:1]};
            end
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    function automatic logic [7:0] eff_length();
        return (cur_length < LEN_MIN) ? LEN_MIN : cur_length;
    endfunction

    task automatic push_beat(input logic [7:0] data, input logic last);
        frame_beat_t beat;
        beat.data = data;
        beat.last = last;
        pending_beats.push_back(beat);
    endtask

    task automatic predict_frame_beats(input logic [7:0] b);
        logic [7:0] len;
        logic [7:0] acc;
        len = eff_length();
        acc = frame_crc;
        if (frame_pos == 8'd0)
        begin
            acc = crc8_update(8'd0, HDR0_BYTE);
            acc = crc8_update(acc, HDR1_BYTE);
            acc = crc8_update(acc, len);
            push_beat(HDR0_BYTE, 1'b0);
            push_beat(HDR1_BYTE, 1'b0);
            push_beat(len, 1'b0);
        end
        acc = crc8_update(acc, b);
        push_beat(b, 1'b0);
        if (int'(frame_pos) + 1 >= int'(len))
        begin
            push_beat(acc, 1'b0);
            push_beat(TRL0_BYTE, 1'b0);
            push_beat(TRL1_BYTE, 1'b1);
            frame_pos = 8'd0;
            frame_crc = 8'd0;
            frames_done++;
        end
        else
        begin
            frame_pos = frame_pos + 8'd1;
            frame_crc = acc;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // called at a falling edge; leaves tvalid high for a back-to-back beat
    task automatic send_payload(input logic [7:0] b);
        int gap;
        gap = gaps_on ? gap_len() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_frame_beats(b);
        payload_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_length(input logic [7:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_length = value;
        settings_written++;
    endtask

    // output side: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            rx_stall    = rx_hold_req;
            rx_hold_req = 0;
        end
        else if (rx_stall == 0 && gaps_on)
        begin
            rx_stall = gap_len();
        end
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat data %02h last %b", m_tdata, m_tlast));
            end
            else
            begin
                want = pending_beats.pop_front();
                beats_checked++;
                if (m_tdata !== want.data)
                begin
                    report_mismatch($sformatf("tdata %02h, expected %02h", m_tdata, want.data));
                end
                if (m_tlast !== want.last)
                begin
                    report_mismatch($sformatf("tlast %b, expected %b (tdata %02h)",
                                              m_tlast, want.last, want.data));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("crc8_frame_builder_top regression: fail");
            $finish;
        end
    end

    // reset length, extreme and look-alike payload values
    task automatic test_reset_length();
        logic [7:0] vals[10];
        vals = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, HDR0_BYTE, TRL1_BYTE};
        gaps_on = 1'b0;
        foreach (vals[i])
        begin
            send_payload(vals[i]);
        end
    endtask

    // lengths below two are sent as two
    task automatic test_short_lengths();
        write_length(8'd1);
        send_payload(8'h3C);
        send_payload(8'hC3);
        write_length(8'd0);
        send_payload(8'hFF);
        send_payload(8'h00);
        write_length(8'd2);
        send_payload(8'h5A);
        send_payload(8'hA5);
    endtask

    // shrinking the length while a frame is open closes it on the next byte
    task automatic test_length_change_mid_frame();
        write_length(8'd255);
        send_payload(8'h11);
        send_payload(8'h22);
        send_payload(8'h33);
        write_length(8'd4);
        send_payload(8'h44);
        write_length(8'd6);
        send_payload(8'h66);
        send_payload(8'h99);
        write_length(8'd1);
        send_payload(8'hE7);
    endtask

    task automatic test_random_frames(input int target);
        int         r;
        int         count;
        logic [7:0] len;
        gaps_on = 1'b1;
        while (payload_sent < target)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                write_length(8'($urandom_range(0, 1)));
            end
            else if (r == 1)
            begin
                write_length(8'($urandom_range(13, 40)));
            end
            else
            begin
                write_length(8'($urandom_range(2, 12)));
            end
            len = eff_length();
            if ($urandom_range(0, 3) != 0)
            begin
                // whole frames, finishing any frame left open
                count = (int'(frame_pos) + 1 >= int'(len)) ? 1 : int'(len) - int'(frame_pos);
                count += int'(len) * $urandom_range(0, 2);
            end
            else
            begin
                count = $urandom_range(1, 2 * int'(len));
            end
            repeat (count)
            begin
                send_payload(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // long output hold-off fills the queue and stalls the input
    task automatic test_output_stall();
        gaps_on = 1'b0;
        write_length(8'd3);
        @(posedge clk);
        rx_hold_req = 80;
        @(negedge clk);
        repeat (20)
        begin
            send_payload(8'($urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        write_length(8'd5);
        repeat (25)
        begin
            send_payload(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_length();
        test_short_lengths();
        test_length_change_mid_frame();
        test_random_frames(payload_sent + 200);
        test_output_stall();
        test_back_to_back();

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (pending_beats.size() != 0)
        begin
            report_mismatch($sformatf("%0d frame beats never arrived", pending_beats.size()));
        end

        $display("covered %0d payload beats, %0d frames, %0d length writes",
                 payload_sent, frames_done, settings_written);
        $display("checked %0d frame beats, %0d mismatches", beats_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("crc8_frame_builder_top regression: pass");
        end
        else
        begin
            $display("crc8_frame_builder_top regression: fail");
        end
        $finish;
    end

endmodule
